FILE: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and codes shared by the sorted list table block.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_UPDATE   = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_DUMP_FWD = 3'd4,
    CMD_DUMP_BWD = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FIX_F,
    S_FIX_B,
    S_FIX_CAP,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  // result of the shared compare unit
  typedef struct packed {
    logic lt;   // entry < key, signed
    logic eq;   // entry == key
    logic hit;  // position found for the current search
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/slt_if.sv
// ----------------------------------------------------------------------------
// slt_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic signed [31:0] new_value;

  modport source (output valid, output cmd, output value, output new_value, input ready);
  modport sink   (input valid, input cmd, input value, input new_value, output ready);
endinterface

interface slt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               element_valid;
  logic               last;
  logic [4:0]         entry_count;
  logic               is_empty;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;

  modport source (output valid, output status, output element, output element_valid,
                  output last, output entry_count, output is_empty, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input status, input element, input element_valid,
                  input last, input entry_count, input is_empty, input front_value,
                  input back_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/slt_cmp_unit.sv
// ----------------------------------------------------------------------------
// slt_cmp_unit
// Shared compare unit: signed less-than and equality of entry against key.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cmp_unit import slt_pkg::*; (
  input  wire logic [DATA_W-1:0] entry_i,
  input  wire logic [DATA_W-1:0] key_i,
  input  wire logic              ins_mode_i,
  output      cmp_res_t          res_o
);

  always_comb begin
    res_o.lt  = $signed(entry_i) < $signed(key_i);
    res_o.eq  = entry_i == key_i;
    // insert stops at the first entry not less than the key
    res_o.hit = ins_mode_i ? !res_o.lt : res_o.eq;
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_list_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Bounded ordered list of signed values held in a RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  in_i      in   cmd, value, new_value
//  out_o     out  status, element, element_valid, last, entry_count, is_empty,
//                 front_value, back_value
//
//  Each visited entry is read through the single-read-port RAM; a dump reads
//  one entry per beat, and clear and full/empty cases go straight to S_RESP.
//  in_i.ready is high only between commands; a result waiting in the output
//  register does not block the next command. Reset clears the count and the
//  sequencer registers but not the RAM or the front/back copies.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_unit import slt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  slt_in_if.sink    in_i,
  slt_out_if.source out_o
);

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [DATA_W-1:0] val_q, nval_q;
  logic [CNT_W-1:0]  count_q, ptr_q, pos_q;
  logic [DATA_W-1:0] front_q, back_q;
  status_e           status_q;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  cmp_res_t          cmp;

  logic              out_valid_q, slot_free, out_load, out_dump, out_last;
  logic [1:0]        out_status_q;
  logic [DATA_W-1:0] out_elem_q, out_front_q, out_back_q;
  logic              out_ev_q, out_last_q, out_empty_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              in_acc, is_ins, is_rem;
  logic [CNT_W-1:0]  ptr_inc, ptr_dec, cnt_dec, rev_idx;

  assign in_acc  = in_i.valid && in_i.ready;
  assign is_ins  = cmd_q == CMD_INSERT;
  assign is_rem  = cmd_q == CMD_REMOVE;
  assign ptr_inc = ptr_q + CNT_W'(1);
  assign ptr_dec = ptr_q - CNT_W'(1);
  assign cnt_dec = count_q - CNT_W'(1);
  assign rev_idx = cnt_dec - ptr_q;
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready = state_q == S_IDLE;

  slt_ram #(.Width(DATA_W), .Depth(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  slt_cmp_unit u_cmp (
    .entry_i    (ram_rdata),
    .key_i      (val_q),
    .ins_mode_i (is_ins),
    .res_o      (cmp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_i.cmd))
            CMD_INSERT:
              state_d = (count_q == CNT_W'(CAPACITY)) ? S_RESP : S_FIND_RD;
            CMD_REMOVE, CMD_UPDATE:
              state_d = (count_q == '0) ? S_RESP : S_FIND_RD;
            CMD_DUMP_FWD, CMD_DUMP_BWD:
              state_d = (count_q == '0) ? S_RESP : S_DUMP_RD;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_FIND_RD: begin
        if (ptr_q == count_q) state_d = is_ins ? S_SHIFT_RD : S_RESP;
        else                  state_d = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (!cmp.hit)    state_d = S_FIND_RD;
        else if (is_ins || is_rem) state_d = S_SHIFT_RD;
        else             state_d = S_PUT;
      end
      S_SHIFT_RD: begin
        if (is_ins) state_d = (ptr_q > pos_q) ? S_SHIFT_WR : S_PUT;
        else        state_d = (ptr_inc < count_q) ? S_SHIFT_WR : S_FIX_F;
      end
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_PUT:      state_d = S_FIX_F;
      S_FIX_F:    state_d = S_FIX_B;
      S_FIX_B:    state_d = S_FIX_CAP;
      S_FIX_CAP:  state_d = S_RESP;
      S_DUMP_RD:  state_d = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (slot_free) state_d = (ptr_inc == count_q) ? S_IDLE : S_DUMP_RD;
      end
      S_RESP: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // RAM and output-register controls
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_q[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = ptr_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    out_load  = 1'b0;
    out_dump  = 1'b0;
    out_last  = 1'b1;
    unique case (state_q)
      S_FIND_RD: ram_re = ptr_q != count_q;
      S_SHIFT_RD: begin
        if (is_ins) begin
          ram_re    = ptr_q > pos_q;
          ram_raddr = ptr_dec[IDX_W-1:0];
        end else begin
          ram_re    = ptr_inc < count_q;
          ram_raddr = ptr_inc[IDX_W-1:0];
        end
      end
      S_SHIFT_WR: ram_we = 1'b1;
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IDX_W-1:0];
        ram_wdata = is_ins ? val_q : nval_q;
      end
      S_FIX_F: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_FIX_B: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_dec[IDX_W-1:0];
      end
      S_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = (cmd_q == CMD_DUMP_FWD) ? ptr_q[IDX_W-1:0] : rev_idx[IDX_W-1:0];
      end
      S_DUMP_OUT: begin
        out_load = slot_free;
        out_dump = 1'b1;
        out_last = ptr_inc == count_q;
      end
      S_RESP: out_load = slot_free;
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      pos_q    <= '0;
      status_q <= ST_OK;
      cmd_q    <= CMD_INSERT;
      val_q    <= '0;
      nval_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q    <= cmd_e'(in_i.cmd);
            val_q    <= in_i.value;
            nval_q   <= in_i.new_value;
            ptr_q    <= '0;
            status_q <= ST_OK;
            case (cmd_e'(in_i.cmd))
              CMD_INSERT:
                if (count_q == CNT_W'(CAPACITY)) status_q <= ST_FULL;
              CMD_REMOVE, CMD_UPDATE, CMD_DUMP_FWD, CMD_DUMP_BWD:
                if (count_q == '0) status_q <= ST_EMPTY;
              CMD_CLEAR: count_q <= '0;
              default: ;
            endcase
          end
        end
        S_FIND_RD: begin
          if (ptr_q == count_q) begin
            if (is_ins) pos_q <= count_q;
            else        status_q <= ST_NOT_FOUND;
          end
        end
        S_FIND_CMP: begin
          if (cmp.hit) begin
            pos_q <= ptr_q;
            if (is_ins) ptr_q <= count_q;
          end else begin
            ptr_q <= ptr_inc;
          end
        end
        S_SHIFT_RD: begin
          if (!is_ins && !(ptr_inc < count_q)) count_q <= cnt_dec;
        end
        S_SHIFT_WR: ptr_q <= is_ins ? ptr_dec : ptr_inc;
        S_PUT: begin
          if (is_ins) count_q <= count_q + CNT_W'(1);
        end
        S_DUMP_OUT: begin
          if (slot_free) ptr_q <= ptr_inc;
        end
        default: ;
      endcase
    end
  end

  // front/back copies, refreshed after every insert, remove or update that changes the list
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIX_B)   front_q <= ram_rdata;
    if (state_q == S_FIX_CAP) back_q  <= ram_rdata;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_elem_q   <= out_dump ? ram_rdata : '0;
      out_ev_q     <= out_dump;
      out_last_q   <= out_last;
      out_count_q  <= count_q;
      out_empty_q  <= count_q == '0;
      out_front_q  <= (count_q == '0) ? '0 : front_q;
      out_back_q   <= (count_q == '0) ? '0 : back_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.element       = out_elem_q;
  assign out_o.element_valid = out_ev_q;
  assign out_o.last          = out_last_q;
  assign out_o.entry_count   = out_count_q;
  assign out_o.is_empty      = out_empty_q;
  assign out_o.front_value   = out_front_q;
  assign out_o.back_value    = out_back_q;

endmodule

`default_nettype wire

FILE: test/tb_sorted_list_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_table_unit
// Drives list commands (insert, remove, update, clear, forward and backward
// dumps) into sorted_list_table_unit with random gaps on both channels. A
// software copy of the list predicts every result beat, and the beats are
// checked field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_sorted_list_table_unit;
  import slt_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          END_WAIT    = 2 * CAPACITY + 20;
  localparam int          SEG_LEN     = 50;
  localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;

  typedef struct {
    status_e            status;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } list_beat_t;

  logic clk_i;
  logic rst_ni;

  slt_in_if  cmd_if ();
  slt_out_if res_if ();

  sorted_list_table_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // shadow copy of the list
  logic signed [31:0] list_mem [CAPACITY];
  int                 list_cnt;

  list_beat_t expected_beats [$];
  list_beat_t want_beat;

  int err_cnt;
  int cycle_cnt;
  int cmds_sent;
  int beats_checked;
  int full_drops;
  int peak_cnt;
  int send_idle;
  int recv_idle;
  int recv_stall;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               expected_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic void push_beat(status_e st, logic signed [31:0] elem, logic ev,
                                    logic lst);
    list_beat_t b;
    b.status        = st;
    b.element       = elem;
    b.element_valid = ev;
    b.last          = lst;
    b.entry_count   = list_cnt[4:0];
    b.is_empty      = (list_cnt == 0);
    b.front_value   = (list_cnt != 0) ? list_mem[0] : '0;
    b.back_value    = (list_cnt != 0) ? list_mem[list_cnt-1] : '0;
    expected_beats.push_back(b);
  endfunction

  function automatic int find_first_equal(logic signed [31:0] val);
    int i;
    for (i = 0; i < list_cnt; i++)
      if (list_mem[i] == val) return i;
    return list_cnt;
  endfunction

  function automatic void predict_list_op(cmd_e op, logic signed [31:0] val,
                                          logic signed [31:0] nval);
    int      pos;
    int      i;
    status_e st;
    st = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (list_cnt >= CAPACITY) begin
          st = ST_FULL;
          full_drops++;
        end else begin
          pos = 0;
          while (pos < list_cnt && list_mem[pos] < val) pos++;
          for (i = list_cnt; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_cnt++;
          if (list_cnt > peak_cnt) peak_cnt = list_cnt;
        end
      end
      CMD_REMOVE, CMD_UPDATE: begin
        if (list_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          pos = find_first_equal(val);
          if (pos >= list_cnt) begin
            st = ST_NOT_FOUND;
          end else if (op == CMD_UPDATE) begin
            list_mem[pos] = nval;
          end else begin
            for (i = pos; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
            list_cnt--;
          end
        end
      end
      CMD_CLEAR: list_cnt = 0;
      CMD_DUMP_FWD, CMD_DUMP_BWD: begin
        if (list_cnt == 0) begin
          push_beat(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < list_cnt; i++)
            push_beat(ST_OK, list_mem[(op == CMD_DUMP_FWD) ? i : list_cnt - 1 - i],
                      1'b1, (i + 1 == list_cnt));
        end
        return;
      end
      default: ;
    endcase
    push_beat(st, '0, 1'b0, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (err_cnt < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got %h, want %h", beats_checked, fname,
                                got, want));
  endtask

  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("status",        res_if.status,        want_beat.status);
        check_field("element",       res_if.element,       want_beat.element);
        check_field("element_valid", res_if.element_valid, want_beat.element_valid);
        check_field("last",          res_if.last,          want_beat.last);
        check_field("entry_count",   res_if.entry_count,   want_beat.entry_count);
        check_field("is_empty",      res_if.is_empty,      want_beat.is_empty);
        check_field("front_value",   res_if.front_value,   want_beat.front_value);
        check_field("back_value",    res_if.back_value,    want_beat.back_value);
      end
      beats_checked++;
      recv_stall = draw_gap(recv_idle);
    end
  end

  // receiver back-pressure, recv_stall counted down at each falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= (recv_stall == 0);
      if (recv_stall > 0) recv_stall--;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic send_cmd(cmd_e op, logic signed [31:0] val, logic signed [31:0] nval);
    int gap;
    gap = draw_gap(send_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.cmd       <= op;
    cmd_if.value     <= val;
    cmd_if.new_value <= nval;
    cmd_if.valid     <= 1'b1;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    predict_list_op(op, val, nval);
    cmds_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0, 1: begin
        if (list_cnt > 0) return list_mem[$urandom_range(0, list_cnt - 1)];
        return $signed($urandom_range(0, 16)) - 8;
      end
      2:       return $signed($urandom_range(0, 16)) - 8;
      default: begin
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        return $urandom;
      end
    endcase
  endfunction

  task automatic test_empty_list();
    send_cmd(CMD_DUMP_FWD, 0, 0);
    send_cmd(CMD_DUMP_BWD, 0, 0);
    send_cmd(CMD_REMOVE, 0, 0);
    send_cmd(CMD_UPDATE, 0, 1);
    send_cmd(CMD_CLEAR, 0, 0);
  endtask

  task automatic test_edge_values();
    send_cmd(CMD_INSERT, VAL_MAX, 0);
    send_cmd(CMD_INSERT, VAL_MIN, 0);
    send_cmd(CMD_INSERT, 0, 0);
    send_cmd(CMD_INSERT, 0, 0);
    // min becomes max at the front: list is no longer sorted
    send_cmd(CMD_UPDATE, VAL_MIN, VAL_MAX);
    send_cmd(CMD_INSERT, 1, 0);
    send_cmd(CMD_REMOVE, 0, 0);
    send_cmd(CMD_UPDATE, 12345, 7);
    send_cmd(CMD_REMOVE, 999, 0);
    send_cmd(CMD_DUMP_FWD, 0, 0);
    send_cmd(CMD_DUMP_BWD, 0, 0);
  endtask

  task automatic test_capacity();
    while (list_cnt < CAPACITY) send_cmd(CMD_INSERT, $urandom, 0);
    send_cmd(CMD_INSERT, VAL_MIN, 0);
    send_cmd(CMD_DUMP_FWD, 0, 0);
    send_cmd(CMD_DUMP_BWD, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_DUMP_FWD, 0, 0);
  endtask

  // segments lean towards filling, draining or a mix, each with its own idle mode
  task automatic test_random_ops(int n_items);
    int   i;
    int   seg_kind;
    int   roll;
    int   ins_w;
    int   rem_w;
    cmd_e op;
    seg_kind = 0;
    for (i = 0; i < n_items; i++) begin
      if (i % SEG_LEN == 0) begin
        seg_kind  = $urandom_range(0, 2);
        send_idle = $urandom_range(0, 2);
        recv_idle = $urandom_range(0, 2);
      end
      ins_w = (seg_kind == 1) ? 70 : (seg_kind == 2) ? 15 : 40;
      rem_w = (seg_kind == 2) ? 50 : 20;
      roll  = $urandom_range(0, 99);
      if (roll < ins_w)              op = CMD_INSERT;
      else if (roll < ins_w + rem_w) op = CMD_REMOVE;
      else if (roll < ins_w + rem_w + 12) op = CMD_UPDATE;
      else if (roll < ins_w + rem_w + 15) op = CMD_CLEAR;
      else if (roll < ins_w + rem_w + 15 + (100 - ins_w - rem_w - 15) / 2)
        op = CMD_DUMP_FWD;
      else op = CMD_DUMP_BWD;
      send_cmd(op, pick_value(), ($urandom_range(0, 1) ? pick_value() : $urandom));
    end
  endtask

  task automatic drain_results();
    int waited;
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < END_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd       = CMD_CLEAR;
    cmd_if.value     = '0;
    cmd_if.new_value = '0;
    res_if.ready     = 1'b0;
    list_cnt         = 0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    cmds_sent        = 0;
    beats_checked    = 0;
    full_drops       = 0;
    peak_cnt         = 0;
    recv_stall       = 0;
    send_idle        = 1;
    recv_idle        = 1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_edge_values();
    test_capacity();
    test_random_ops(500);
    drain_results();

    $display("%0d commands sent, %0d result beats checked, %0d cycles", cmds_sent,
             beats_checked, cycle_cnt);
    $display("list peaked at %0d entries, %0d inserts dropped on a full list", peak_cnt,
             full_drops);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/slt_pkg.sv
rtl/slt_if.sv
rtl/slt_ram.sv
rtl/slt_cmp_unit.sv
rtl/sorted_list_table_unit.sv
test/tb_sorted_list_table_unit.sv
